FILE: sv/link_sequence_replay_tracker_core_assert.svh
`ifndef LINK_SEQUENCE_REPLAY_TRACKER_CORE_ASSERT_SVH
`define LINK_SEQUENCE_REPLAY_TRACKER_CORE_ASSERT_SVH

// same-cycle implication
`define LSRT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsrt assertion failed");

// next-cycle implication
`define LSRT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsrt assertion failed");

`endif

FILE: sv/lsrt_pkg.sv
package lsrt_pkg;

    typedef logic [1:0] verdict_t;

    localparam verdict_t VERDICT_NEW      = 2'd0;
    localparam verdict_t VERDICT_NEW_BOOT = 2'd1;
    localparam verdict_t VERDICT_RETRY    = 2'd2;
    localparam verdict_t VERDICT_STALE    = 2'd3;

    localparam int SEQ_W  = 32;
    localparam int BOOT_W = 32;
    localparam int CHAN_W = 8;

endpackage

FILE: sv/lsrt_if.sv
interface lsrt_frame_if;
    logic                          valid;
    logic                          ready;
    logic [lsrt_pkg::BOOT_W-1:0]   sender_boot;
    logic [lsrt_pkg::CHAN_W-1:0]   chan;
    logic [lsrt_pkg::SEQ_W-1:0]    seq_num;

    modport source (output valid, output sender_boot, output chan, output seq_num,
                    input ready);
    modport sink   (input valid, input sender_boot, input chan, input seq_num,
                    output ready);
endinterface

interface lsrt_status_if;
    logic                valid;
    logic                ready;
    lsrt_pkg::verdict_t  verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

FILE: sv/link_sequence_replay_tracker_core.sv
// channel  | role | payload
// frame    | sink | sender_boot[31:0], chan[7:0], seq_num[31:0]
// status   | src  | verdict[1:0]
//
// Per item: accept reads last_seq from the channel memory (one port, registered
// read), then the judge state judges and writes back.
// One item in flight; a new item is taken while a finished verdict waits in
// the output register; judging holds while it is full and not being taken.
// Reset clears boot state and all seen flags at once; no clearing pass.
module link_sequence_replay_tracker_core #(
    parameter int CHANNELS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    lsrt_frame_if.sink         frame,
    lsrt_status_if.source      status
);

    localparam int            CW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [8:0]    CHAN_LIMIT = 9'(CHANNELS);
    localparam logic          ST_IDLE    = 1'b0;
    localparam logic          ST_JUDGE   = 1'b1;

    logic                          state_reg, state_next;
    logic [lsrt_pkg::BOOT_W-1:0]   cur_boot_reg, cur_boot_next;
    logic                          boot_known_reg, boot_known_next;
    logic [CHANNELS-1:0]           seen_reg, seen_next;
    logic                          out_valid_reg, out_valid_next;
    lsrt_pkg::verdict_t            verdict_reg, verdict_next;

    logic [lsrt_pkg::BOOT_W-1:0]   boot_q_reg;
    logic [lsrt_pkg::SEQ_W-1:0]    seq_q_reg;
    logic [CW-1:0]                 idx_q_reg;
    logic                          in_range_q_reg;

    logic [lsrt_pkg::SEQ_W-1:0]    seq_mem [CHANNELS];
    logic [lsrt_pkg::SEQ_W-1:0]    rdata_reg;

    logic                          accept;
    logic                          in_range;
    logic                          finish;
    logic                          new_boot;
    logic                          seen;
    logic [lsrt_pkg::SEQ_W-1:0]    diff;
    logic                          mem_we;

    assign in_range     = ({1'b0, frame.chan} < CHAN_LIMIT);
    assign frame.ready  = (state_reg == ST_IDLE);
    assign accept       = frame.valid && frame.ready;
    assign finish       = (state_reg == ST_JUDGE) && (!out_valid_reg || status.ready);
    assign status.valid   = out_valid_reg;
    assign status.verdict = verdict_reg;

    assign new_boot = !boot_known_reg || (boot_q_reg != cur_boot_reg);
    assign seen     = seen_reg[idx_q_reg];
    assign diff     = seq_q_reg - rdata_reg;

    always_comb
    begin
        state_next      = state_reg;
        cur_boot_next   = cur_boot_reg;
        boot_known_next = boot_known_reg;
        seen_next       = seen_reg;
        out_valid_next  = out_valid_reg;
        verdict_next    = verdict_reg;
        mem_we          = 1'b0;

        if (out_valid_reg && status.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE:
            begin
                if (finish)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (!in_range_q_reg)
                    begin
                        verdict_next = lsrt_pkg::VERDICT_STALE;
                    end
                    else if (new_boot)
                    begin
                        verdict_next         = lsrt_pkg::VERDICT_NEW_BOOT;
                        cur_boot_next        = boot_q_reg;
                        boot_known_next      = 1'b1;
                        seen_next            = '0;
                        seen_next[idx_q_reg] = 1'b1;
                        mem_we               = 1'b1;
                    end
                    else if (!seen)
                    begin
                        verdict_next         = lsrt_pkg::VERDICT_NEW;
                        seen_next[idx_q_reg] = 1'b1;
                        mem_we               = 1'b1;
                    end
                    else if (rdata_reg == seq_q_reg)
                    begin
                        verdict_next = lsrt_pkg::VERDICT_RETRY;
                    end
                    else if (diff[lsrt_pkg::SEQ_W-1])
                    begin
                        verdict_next = lsrt_pkg::VERDICT_STALE;
                    end
                    else
                    begin
                        verdict_next = lsrt_pkg::VERDICT_NEW;
                        mem_we       = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_boot_reg   <= '0;
            boot_known_reg <= 1'b0;
            seen_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_boot_reg   <= cur_boot_next;
            boot_known_reg <= boot_known_next;
            seen_reg       <= seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        if (accept)
        begin
            boot_q_reg     <= frame.sender_boot;
            seq_q_reg      <= frame.seq_num;
            idx_q_reg      <= frame.chan[CW-1:0];
            in_range_q_reg <= in_range;
        end
    end

    // last_seq store: read at an in-range accept, written when judging advances it
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seq_mem[idx_q_reg] <= seq_q_reg;
        end
        if (accept && in_range)
        begin
            rdata_reg <= seq_mem[frame.chan[CW-1:0]];
        end
    end

endmodule

FILE: sv/lsrt_checker.sv
`include "link_sequence_replay_tracker_core_assert.svh"

module lsrt_checker #(
    parameter int CHANNELS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [lsrt_pkg::CHAN_W-1:0] in_chan,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  lsrt_pkg::verdict_t          out_verdict
);

    localparam logic [8:0] CHAN_LIMIT = 9'(CHANNELS);

    logic in_acc;
    logic out_free;
    logic out_stall;
    logic chan_bad;
    logic bad_acc;
    logic is_stale;

    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid || out_ready;
    assign out_stall = out_valid && !out_ready;
    assign chan_bad  = ({1'b0, in_chan} >= CHAN_LIMIT);
    assign bad_acc   = in_acc && chan_bad;
    assign is_stale  = (out_verdict == lsrt_pkg::VERDICT_STALE);

    `LSRT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_verdict))
    `LSRT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_acc, !in_ready)
    `LSRT_ASSERT_NEXT(a_result_follows, clk, rst_n, in_acc ##1 out_free, out_valid)
    `LSRT_ASSERT_NEXT(a_bad_chan_stale, clk, rst_n, bad_acc ##1 out_free, is_stale)

endmodule

bind link_sequence_replay_tracker_core lsrt_checker #(.CHANNELS(CHANNELS)) u_lsrt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (frame.valid),
    .in_ready    (frame.ready),
    .in_chan     (frame.chan),
    .out_valid   (status.valid),
    .out_ready   (status.ready),
    .out_verdict (status.verdict)
);

FILE: sim/tb_top.sv
module tb_top;

    localparam int CHANNELS  = 4;
    localparam int HOLD_LONG = 300;

    class verdict_scoreboard;
        logic [lsrt_pkg::BOOT_W-1:0] cur_boot;
        bit                          boot_known;
        logic [lsrt_pkg::SEQ_W-1:0]  last_seq [CHANNELS];
        bit                          chan_seen [CHANNELS];
        lsrt_pkg::verdict_t          verdict_q [$];
        int                          errors;

        function new();
            cur_boot   = '0;
            boot_known = 1'b0;
            errors     = 0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                last_seq[i]  = '0;
                chan_seen[i] = 1'b0;
            end
        endfunction

        // predict the verdict of an accepted frame and advance the tracker state
        function void note_frame(logic [lsrt_pkg::BOOT_W-1:0] boot,
                                 logic [lsrt_pkg::CHAN_W-1:0] ch,
                                 logic [lsrt_pkg::SEQ_W-1:0] seq);
            lsrt_pkg::verdict_t         v;
            logic [lsrt_pkg::SEQ_W-1:0] seq_gap;
            if (ch >= CHANNELS)
            begin
                v = lsrt_pkg::VERDICT_STALE;
            end
            else if (!boot_known || boot != cur_boot)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    last_seq[i]  = '0;
                    chan_seen[i] = 1'b0;
                end
                cur_boot      = boot;
                boot_known    = 1'b1;
                last_seq[ch]  = seq;
                chan_seen[ch] = 1'b1;
                v = lsrt_pkg::VERDICT_NEW_BOOT;
            end
            else if (!chan_seen[ch])
            begin
                last_seq[ch]  = seq;
                chan_seen[ch] = 1'b1;
                v = lsrt_pkg::VERDICT_NEW;
            end
            else if (last_seq[ch] == seq)
            begin
                v = lsrt_pkg::VERDICT_RETRY;
            end
            else
            begin
                seq_gap = seq - last_seq[ch];
                if (seq_gap[lsrt_pkg::SEQ_W-1])
                begin
                    v = lsrt_pkg::VERDICT_STALE;
                end
                else
                begin
                    last_seq[ch] = seq;
                    v = lsrt_pkg::VERDICT_NEW;
                end
            end
            verdict_q.push_back(v);
        endfunction

        function void check_verdict(lsrt_pkg::verdict_t got);
            lsrt_pkg::verdict_t exp_v;
            if (verdict_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected verdict: expected none, actual %0d", $time, got);
            end
            else
            begin
                exp_v = verdict_q.pop_front();
                if (got !== exp_v)
                begin
                    errors++;
                    $display("%0t verdict mismatch: expected %0d, actual %0d",
                             $time, exp_v, got);
                end
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lsrt_frame_if  frame_bus ();
    lsrt_status_if status_bus ();

    link_sequence_replay_tracker_core #(
        .CHANNELS (CHANNELS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_bus),
        .status (status_bus)
    );

    verdict_scoreboard sb = new();

    int src_idle_pct;
    int sink_stall_pct;
    bit hold_req;
    bit hold_ack;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // status receiver: random stalls, long hold on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        hold_ack = 1'b0;
        status_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (status_bus.valid && status_bus.ready)
                    sb.check_verdict(status_bus.verdict);
                if (hold_req != hold_ack)
                begin
                    hold_left = HOLD_LONG;
                    hold_ack  = hold_req;
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                    status_bus.ready <= 1'b0;
                end
                else
                begin
                    status_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
                end
            end
        end
    end

    task automatic send_frame(input logic [lsrt_pkg::BOOT_W-1:0] boot,
                              input logic [lsrt_pkg::CHAN_W-1:0] ch,
                              input logic [lsrt_pkg::SEQ_W-1:0] seq);
        while ($urandom_range(99) < src_idle_pct)
        begin
            frame_bus.valid <= 1'b0;
            @(posedge clk);
        end
        frame_bus.valid       <= 1'b1;
        frame_bus.sender_boot <= boot;
        frame_bus.chan        <= ch;
        frame_bus.seq_num     <= seq;
        do
            @(posedge clk);
        while (!frame_bus.ready);
        sb.note_frame(boot, ch, seq);
    endtask

    // mostly well-formed traffic on the current boot, some boot changes and bad channels
    task automatic send_random();
        logic [lsrt_pkg::BOOT_W-1:0] boot;
        logic [lsrt_pkg::CHAN_W-1:0] ch;
        logic [lsrt_pkg::SEQ_W-1:0]  seq;
        logic [lsrt_pkg::SEQ_W-1:0]  prev;
        int                          pick;
        pick = $urandom_range(99);
        ch   = 8'($urandom_range(CHANNELS - 1));
        boot = sb.cur_boot;
        if (!sb.boot_known || pick < 3)
            boot = $urandom();
        else if (pick < 9)
        begin
            ch = 8'($urandom_range(255, CHANNELS));
            if (pick < 6)
                boot = $urandom();
        end
        seq = $urandom();
        if (ch < CHANNELS && sb.chan_seen[ch])
        begin
            prev = sb.last_seq[ch];
            pick = $urandom_range(99);
            if (pick < 50)
                seq = prev + $urandom_range(1, 16);
            else if (pick < 62)
                seq = prev;
            else if (pick < 74)
                seq = prev - $urandom_range(1, 16);
            else if (pick < 78)
                seq = prev + 32'h8000_0000;
            else if (pick < 83)
                seq = prev + 32'h7FFF_FFFF;
            else if (pick < 86)
                seq = prev + 32'h8000_0001;
        end
        send_frame(boot, ch, seq);
    endtask

    task automatic drain();
        frame_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int items, input int idle_pct, input int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (items)
            send_random();
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        hold_req = 1'b0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        frame_bus.valid       <= 1'b0;
        frame_bus.sender_boot <= '0;
        frame_bus.chan        <= '0;
        frame_bus.seq_num     <= '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // boot zero right after reset is still a new boot
        send_frame(32'h0000_0000, 8'd0, 32'h0000_0000);
        send_frame(32'h0000_0000, 8'd0, 32'h0000_0000);
        send_frame(32'h0000_0000, 8'd0, 32'h0000_0001);
        send_frame(32'h0000_0000, 8'd0, 32'h0000_0000);
        send_frame(32'h0000_0000, 8'd3, 32'hFFFF_FFFF);
        // wrap-around ahead, then half range, then largest step ahead
        send_frame(32'h0000_0000, 8'd3, 32'h0000_0004);
        send_frame(32'h0000_0000, 8'd3, 32'h8000_0004);
        send_frame(32'h0000_0000, 8'd3, 32'h8000_0003);
        // bad channel, also with a fresh boot id: no state change
        send_frame(32'h0000_0000, 8'd4, 32'h0000_0000);
        send_frame(32'hFFFF_FFFF, 8'd255, 32'h0000_0000);
        send_frame(32'h0000_0000, 8'd0, 32'h0000_0001);
        send_frame(32'hFFFF_FFFF, 8'd1, 32'hFFFF_FFFF);
        send_frame(32'hFFFF_FFFF, 8'd0, 32'h0000_0001);
        send_frame(32'hFFFF_FFFF, 8'd1, 32'hFFFF_FFFF);
        send_frame(32'hFFFF_FFFF, 8'd1, 32'h7FFF_FFFF);
        send_frame(32'hFFFF_FFFF, 8'd2, 32'h8000_0000);
        send_frame(32'hA5A5_A5A5, 8'd2, 32'h5A5A_5A5A);
        send_frame(32'hA5A5_A5A5, 8'd2, 32'h5A5A_5A59);
        send_frame(32'h5A5A_5A5A, 8'd128, 32'hAAAA_AAAA);
        send_frame(32'hA5A5_A5A5, 8'd2, 32'h5A5A_5A5B);
        drain();

        run_phase(300, 0, 0);
        run_phase(300, 56, 0);
        run_phase(300, 0, 56);
        run_phase(300, 8, 8);

        // long receiver hold with the sender pushing back to back
        hold_req = ~hold_req;
        run_phase(80, 0, 0);

        drain();
        repeat (10)
            @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
